[rtl/fbfla_pkg.sv]
// ----------------------------------------------------------------------------
// fbfla_pkg
// Shared widths, request and status codes, register indexes and the
// controller command bundle of the block free-list allocator.
// ----------------------------------------------------------------------------
package fbfla_pkg;

  localparam int REQ_W   = 2;
  localparam int BIDX_W  = 10;
  localparam int OWNER_W = 8;
  localparam int STAT_W  = 2;
  localparam int OFF_W   = 32;

  localparam int BC_W    = 11;
  localparam int BS_W    = 21;
  localparam int PID_W   = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  // request codes
  localparam logic [REQ_W-1:0] REQ_ALLOC   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_RELEASE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_REBUILD = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY      = 2'd1;
  localparam logic [STAT_W-1:0] ST_WRONG_POOL = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE      = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_OFFSET = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_ID      = 2'd3;

  // commands from controller to datapath
  typedef struct packed {
    logic accept;   // input word taken this cycle
    logic commit;   // link read data is back, finish the head update
    logic load;     // load result into output register
  } cmd_t;

endpackage

[rtl/fbfla_in_if.sv]
// ----------------------------------------------------------------------------
// fbfla_in_if
// Request channel: valid/ready handshake with request payload.
// ----------------------------------------------------------------------------
interface fbfla_in_if;
  import fbfla_pkg::*;

  logic               valid;
  logic               ready;
  logic [REQ_W-1:0]   req_type;
  logic [BIDX_W-1:0]  block_index;
  logic [OWNER_W-1:0] owner_id;

  modport source (output valid, output req_type, output block_index, output owner_id,
                  input ready);
  modport sink   (input valid, input req_type, input block_index, input owner_id,
                  output ready);
endinterface

[rtl/fbfla_out_if.sv]
// ----------------------------------------------------------------------------
// fbfla_out_if
// Result channel: valid/ready handshake with allocation result payload.
// ----------------------------------------------------------------------------
interface fbfla_out_if;
  import fbfla_pkg::*;

  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [BIDX_W-1:0] granted_index;
  logic [OFF_W-1:0]  granted_offset;
  logic              pool_empty;

  modport source (output valid, output status, output granted_index,
                  output granted_offset, output pool_empty, input ready);
  modport sink   (input valid, input status, input granted_index,
                  input granted_offset, input pool_empty, output ready);
endinterface

[rtl/fbfla_ram.sv]
// ----------------------------------------------------------------------------
// fbfla_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module fbfla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/fbfla_ctrl.sv]
// ----------------------------------------------------------------------------
// fbfla_ctrl
// Request sequencer: accepts a word, waits in S_FIN for the link read,
// then hands the result to the output register when it is free.
// ----------------------------------------------------------------------------
module fbfla_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output fbfla_pkg::cmd_t cmd
);
  import fbfla_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FIN,
    S_WAIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free   = !out_valid_r || out_ready;
  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;

  always_comb begin
    cmd        = '0;
    cmd.accept = in_ready && in_valid;
    cmd.commit = (state_r == S_FIN);
    cmd.load   = ((state_r == S_FIN) || (state_r == S_WAIT)) && out_free;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.accept) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        state_nxt = out_free ? S_IDLE : S_WAIT;
      end
      S_WAIT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = cmd.load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[rtl/fbfla_dp.sv]
// ----------------------------------------------------------------------------
// fbfla_dp
// Free-list datapath: config registers, released-stack head, fresh counter,
// link RAM, offset multiplier and output register.
// ----------------------------------------------------------------------------
module fbfla_dp #(
  parameter int NUM_BLOCKS = 1024,
  parameter int LINE_BYTES = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  fbfla_pkg::cmd_t                cmd,
  input  logic                           cfg_we,
  input  logic [fbfla_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fbfla_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic [fbfla_pkg::REQ_W-1:0]    req_type,
  input  logic [fbfla_pkg::BIDX_W-1:0]   block_index,
  input  logic [fbfla_pkg::OWNER_W-1:0]  owner_id,
  output logic [fbfla_pkg::STAT_W-1:0]   status,
  output logic [fbfla_pkg::BIDX_W-1:0]   granted_index,
  output logic [fbfla_pkg::OFF_W-1:0]    granted_offset,
  output logic                           pool_empty
);
  import fbfla_pkg::*;

  localparam int HW    = $clog2(NUM_BLOCKS + 1);
  localparam int AW    = $clog2(NUM_BLOCKS);
  localparam int CMP_W = (HW > BC_W) ? HW : BC_W;
  localparam int SZ_W  = BS_W + 1;
  localparam logic [HW-1:0]   NULL_IDX  = HW'(NUM_BLOCKS);
  localparam logic [SZ_W-1:0] LINE_MASK = SZ_W'(LINE_BYTES - 1);

  // configuration
  logic [BC_W-1:0]  block_count_r;
  logic [BS_W-1:0]  block_size_r;
  logic [OFF_W-1:0] first_offset_r;
  logic [PID_W-1:0] pool_id_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_count_r  <= BC_W'(1024);
      block_size_r   <= BS_W'(64);
      first_offset_r <= OFF_W'(64);
      pool_id_r      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BLOCK_COUNT:  block_count_r  <= cfg_wdata[BC_W-1:0];
        CFG_BLOCK_SIZE:   block_size_r   <= cfg_wdata[BS_W-1:0];
        CFG_FIRST_OFFSET: first_offset_r <= cfg_wdata[OFF_W-1:0];
        CFG_POOL_ID:      pool_id_r      <= cfg_wdata[PID_W-1:0];
        default: ;
      endcase
    end
  end

  // effective count and line-rounded block size
  logic [HW-1:0]   eff_cnt;
  logic [SZ_W-1:0] sz_rnd;

  assign eff_cnt = (CMP_W'(block_count_r) > CMP_W'(NUM_BLOCKS)) ? NULL_IDX
                                                                : HW'(block_count_r);
  assign sz_rnd  = (SZ_W'(block_size_r) + LINE_MASK) & ~LINE_MASK;

  // free-list state
  logic [HW-1:0] head_r, head_nxt;
  logic [HW-1:0] fresh_r, fresh_nxt;
  logic          pend_r, pend_nxt;

  // per-item registers
  logic [HW-1:0]     gidx_r;
  logic              grant_r;
  logic [STAT_W-1:0] stat_r;
  logic [OFF_W-1:0]  prod_r;

  // link RAM
  logic          mem_we;
  logic [HW-1:0] rd_data;
  logic [HW-1:0] rd_clamp;

  fbfla_ram #(
    .WIDTH (HW),
    .DEPTH (NUM_BLOCKS)
  ) u_link_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (AW'(block_index)),
    .wdata (head_r),
    .raddr (AW'(head_r)),
    .rdata (rd_data)
  );

  assign rd_clamp = (rd_data > NULL_IDX) ? NULL_IDX : rd_data;

  logic              head_ok, fresh_ok;
  logic [HW-1:0]     gidx_sel;
  logic              grant;
  logic [STAT_W-1:0] stat;
  logic [OFF_W-1:0]  mul_a, mul_b, prod;

  assign head_ok  = (head_r < NULL_IDX);
  assign fresh_ok = (fresh_r < eff_cnt);
  assign gidx_sel = head_ok ? head_r : fresh_r;
  assign mul_a    = OFF_W'(gidx_sel);
  assign mul_b    = OFF_W'(sz_rnd);
  assign prod     = mul_a * mul_b;

  always_comb begin
    head_nxt  = head_r;
    fresh_nxt = fresh_r;
    pend_nxt  = pend_r;
    mem_we    = 1'b0;
    grant     = 1'b0;
    stat      = ST_OK;
    if (cmd.accept) begin
      case (req_type)
        REQ_ALLOC: begin
          if (head_ok) begin
            // new head comes back from the link RAM next cycle
            grant    = 1'b1;
            pend_nxt = 1'b1;
          end else if (fresh_ok) begin
            grant     = 1'b1;
            fresh_nxt = fresh_r + 1'b1;
          end else begin
            stat = ST_EMPTY;
          end
        end
        REQ_RELEASE: begin
          if (owner_id != pool_id_r) begin
            stat = ST_WRONG_POOL;
          end else if (CMP_W'(block_index) >= CMP_W'(eff_cnt)) begin
            stat = ST_RANGE;
          end else begin
            mem_we   = 1'b1;
            head_nxt = HW'(block_index);
          end
        end
        REQ_REBUILD: begin
          head_nxt  = NULL_IDX;
          fresh_nxt = '0;
        end
        default: ;
      endcase
    end
    if (cmd.commit && pend_r) begin
      head_nxt = rd_clamp;
      pend_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= NULL_IDX;
      fresh_r <= '0;
      pend_r  <= 1'b0;
      grant_r <= 1'b0;
    end else begin
      head_r  <= head_nxt;
      fresh_r <= fresh_nxt;
      pend_r  <= pend_nxt;
      if (cmd.accept) begin
        grant_r <= grant;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      gidx_r <= gidx_sel;
      stat_r <= stat;
      prod_r <= prod;
    end
  end

  // free state after this step, head taken from the RAM while still pending
  logic [HW-1:0] head_now;
  logic          none_free;

  assign head_now  = pend_r ? rd_clamp : head_r;
  assign none_free = (head_now >= NULL_IDX) && (fresh_r >= eff_cnt);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      status         <= stat_r;
      granted_index  <= grant_r ? BIDX_W'(gidx_r) : '0;
      granted_offset <= grant_r ? (first_offset_r + prod_r) : '0;
      pool_empty     <= none_free;
    end
  end

endmodule

[rtl/fixed_block_free_list_allocator.sv]
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator
// Fixed-size block pool with a LIFO free list of released blocks in front of
// an ascending counter of never-used blocks.
//
//   channel | dir | words                             | handshake
//   in_ch   | in  | req_type, block_index, owner_id   | valid/ready
//   out_ch  | out | status, granted_index,            | valid/ready
//           |     | granted_offset, pool_empty        |
//   cfg_*   | in  | cfg_index, cfg_wdata              | cfg_we, no stall
//
// In the accept cycle a request reads the head's link from the synchronous
// link RAM and multiplies index by block size; the next cycle installs the
// new head and loads the output register, or S_WAIT holds the load until
// the output frees up. The output register holds a finished word while the
// next request is taken; a stalled output holds the following one in S_WAIT.
// Reset is synchronous and needs no clearing pass; link entries are only read
// after a release wrote them. LINE_BYTES must be a power of two, unchecked.
// ----------------------------------------------------------------------------
module fixed_block_free_list_allocator #(
  parameter int NUM_BLOCKS = 1024,
  parameter int LINE_BYTES = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  fbfla_in_if.sink                         in_ch,
  fbfla_out_if.source                      out_ch,
  input  logic                             cfg_we,
  input  logic [fbfla_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fbfla_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import fbfla_pkg::*;

  cmd_t cmd;

  fbfla_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  fbfla_dp #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .LINE_BYTES (LINE_BYTES)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .req_type       (in_ch.req_type),
    .block_index    (in_ch.block_index),
    .owner_id       (in_ch.owner_id),
    .status         (out_ch.status),
    .granted_index  (out_ch.granted_index),
    .granted_offset (out_ch.granted_offset),
    .pool_empty     (out_ch.pool_empty)
  );

  // every accepted word is committed in the following cycle
  a_accept_commit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> cmd.commit)
    else $error("accepted word not committed next cycle");

  // no new word while the previous one is still finishing
  a_commit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !in_ch.ready)
    else $error("input ready during commit");

  // a result never overwrites an untaken one
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (!out_ch.valid || out_ch.ready))
    else $error("output register overwritten");

  // a word committed without a load holds off the next request instead of being dropped
  a_wait_load: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && !cmd.load) |=> !in_ch.ready)
    else $error("result dropped while output stalled");

endmodule
